// ===== rtl/sdfp_pkg.sv =====
`timescale 1ns / 1ps

package sdfp_pkg;

    localparam int unsigned HDR_LEN       = 9;
    localparam int unsigned POS_W         = 4;
    localparam int unsigned GRP_W         = 3;
    localparam int unsigned SLOT_W        = 16;
    localparam int unsigned OUT_TDATA_W   = 32;

    localparam logic [POS_W-1:0] POS_SLOT_LO = 4'd9;
    localparam logic [POS_W-1:0] POS_SLOT_HI = 4'd10;
    localparam logic [POS_W-1:0] POS_SAT     = 4'd12;

    localparam logic [7:0] TERMINATOR = 8'hf7;

    // one result item as it leaves the decoder
    typedef struct packed {
        logic [SLOT_W-1:0] slot_number;
        logic              msg_valid;
        logic              is_status;
        logic [7:0]        out_byte;
    } t_result;

    // fixed response header: F0 00 20 32 00 01 24 00 78
    function automatic logic [7:0] hdr_byte(input logic [POS_W-1:0] pos);
        logic [7:0] v;
        case (pos)
            4'd0:    v = 8'hf0;
            4'd1:    v = 8'h00;
            4'd2:    v = 8'h20;
            4'd3:    v = 8'h32;
            4'd4:    v = 8'h00;
            4'd5:    v = 8'h01;
            4'd6:    v = 8'h24;
            4'd7:    v = 8'h00;
            4'd8:    v = 8'h78;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/sysex_dump_frame_parser_core.sv =====
`timescale 1ns / 1ps

// channel  dir  tdata                                        tuser / tlast
// s_axis   in   [7:0] in_byte                                tlast: in_last
// m_axis   out  [7:0] out_byte, [8] msg_valid,               tuser: is_status
//               [24:9] slot_number, [31:25] zero
//
// One byte is taken per cycle while s_axis_tready is high; results are registered.
// The byte state updates in the accept cycle; a two-entry output buffer
// holds results, so input stalls only when both entries are full.
// Reset (i_rst_n low, synchronous) clears the parse state and empties the buffer.
module sysex_dump_frame_parser_core
    import sdfp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // [7:0] in_byte
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // out_byte, msg_valid, slot_number
    output logic                   m_axis_tuser    // is_status
);

    logic    accept;
    logic    res_valid;
    t_result res;
    t_result obuf_data;

    assign accept = s_axis_tvalid && s_axis_tready;

    sdfp_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_byte      (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    sdfp_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (res_valid),
        .i_data      (res),
        .o_ready     (s_axis_tready),
        .o_valid     (m_axis_tvalid),
        .i_pop_ready (m_axis_tready),
        .o_data      (obuf_data)
    );

    assign m_axis_tdata = {7'd0, obuf_data.slot_number, obuf_data.msg_valid,
                           obuf_data.out_byte};
    assign m_axis_tuser = obuf_data.is_status;

endmodule

// ===== rtl/sdfp_decode.sv =====
`timescale 1ns / 1ps

module sdfp_decode
    import sdfp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output logic       o_res_valid,
    output t_result    o_res
);

    logic [POS_W-1:0]  r_pos, n_pos;
    logic              r_hdr_ok, n_hdr_ok;
    logic [GRP_W-1:0]  r_grp, n_grp;
    logic [6:0]        r_coll, n_coll;
    logic [7:0]        r_slot_lo, n_slot_lo;
    logic [7:0]        r_slot_hi, n_slot_hi;

    logic [GRP_W-1:0]  bit_sel;
    logic [SLOT_W-1:0] slot_sum;
    logic              msg_ok;

    assign bit_sel  = r_grp - GRP_W'(1);
    assign slot_sum = {8'd0, r_slot_lo} + {1'b0, r_slot_hi, 7'd0};
    assign msg_ok   = r_hdr_ok && (r_pos == POS_SAT) && (i_byte == TERMINATOR);

    always_comb begin
        n_pos       = r_pos;
        n_hdr_ok    = r_hdr_ok;
        n_grp       = r_grp;
        n_coll      = r_coll;
        n_slot_lo   = r_slot_lo;
        n_slot_hi   = r_slot_hi;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_accept) begin
            if (i_last) begin
                o_res_valid       = 1'b1;
                o_res.is_status   = 1'b1;
                o_res.msg_valid   = msg_ok;
                o_res.slot_number = msg_ok ? slot_sum : '0;
                n_pos     = '0;
                n_hdr_ok  = 1'b1;
                n_grp     = '0;
                n_coll    = '0;
                n_slot_lo = '0;
                n_slot_hi = '0;
            end else begin
                if (r_pos < POS_W'(HDR_LEN)) begin
                    if (i_byte != hdr_byte(r_pos)) begin
                        n_hdr_ok = 1'b0;
                    end
                end else if (r_pos == POS_SLOT_LO) begin
                    n_slot_lo = i_byte;
                end else if (r_pos == POS_SLOT_HI) begin
                    n_slot_hi = i_byte;
                end else if (r_grp == '0) begin
                    // collector: bit k is bit 7 of following byte k+1
                    n_coll = i_byte[6:0];
                    n_grp  = GRP_W'(1);
                end else begin
                    o_res_valid    = 1'b1;
                    o_res.out_byte = {r_coll[bit_sel], i_byte[6:0]};
                    n_grp          = r_grp + GRP_W'(1);
                end
                if (r_pos < POS_SAT) begin
                    n_pos = r_pos + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_hdr_ok  <= 1'b1;
            r_grp     <= '0;
            r_coll    <= '0;
            r_slot_lo <= '0;
            r_slot_hi <= '0;
        end else begin
            r_pos     <= n_pos;
            r_hdr_ok  <= n_hdr_ok;
            r_grp     <= n_grp;
            r_coll    <= n_coll;
            r_slot_lo <= n_slot_lo;
            r_slot_hi <= n_slot_hi;
        end
    end

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_SAT)
        else $error("byte position past saturation");

    a_grp_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_grp != '0) |-> (r_pos == POS_SAT))
        else $error("group active outside payload");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_last) |=> (r_pos == '0 && r_grp == '0 && r_hdr_ok))
        else $error("state not cleared after final byte");

endmodule

// ===== rtl/sdfp_obuf.sv =====
`timescale 1ns / 1ps

module sdfp_obuf
    import sdfp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_pop_ready,
    output t_result o_data
);

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    pop;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;
    assign pop     = r_main_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_push;
            end
        end else if (i_push) begin
            if (r_main_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_main_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_skid_valid) begin
                r_main <= r_skid;
            end else if (i_push) begin
                r_main <= i_data;
            end
        end else if (i_push) begin
            if (r_main_valid) begin
                r_skid <= i_data;
            end else begin
                r_main <= i_data;
            end
        end
    end

    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid entry without main entry");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !i_push)
        else $error("transfer pushed into full buffer");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && r_main_valid && !i_pop_ready) |=> r_skid_valid)
        else $error("stalled result lost");

endmodule

// ===== dv/sysex_unpack_checker.sv =====
`timescale 1ns / 1ps

// Watches both stream channels, tracks the frame parse state for each input
// transfer and compares every output transfer with the oldest expected item.
module sysex_unpack_checker
    import sdfp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_tvalid,
    input  logic                   i_in_tready,
    input  logic [7:0]             i_in_tdata,
    input  logic                   i_in_tlast,
    input  logic                   i_out_tvalid,
    input  logic                   i_out_tready,
    input  logic [OUT_TDATA_W-1:0] i_out_tdata,
    input  logic                   i_out_tuser,
    output int                     o_pending,
    output int                     o_errors,
    output int                     o_checked
);

    // F0 00 20 32 00 01 24 00 78, first byte in the low bits
    localparam logic [HDR_LEN*8-1:0] FRAME_HDR = 72'h78_00_24_01_00_32_20_00_f0;

    logic [POS_W-1:0] pos_q;
    logic             hdr_ok_q;
    logic [GRP_W-1:0] grp_q;
    logic [6:0]       hibits_q;
    logic [7:0]       slot_lo_q;
    logic [7:0]       slot_hi_q;

    t_result decoded_q[$];
    int      err_cnt = 0;
    int      chk_cnt = 0;

    assign o_errors  = err_cnt;
    assign o_checked = chk_cnt;

    function automatic void clear_frame();
        pos_q     = '0;
        hdr_ok_q  = 1'b1;
        grp_q     = '0;
        hibits_q  = '0;
        slot_lo_q = '0;
        slot_hi_q = '0;
    endfunction

    // advances the parse state by one byte; returns 1 when an item comes out
    function automatic bit unpack_byte(input logic [7:0] b, input logic last,
                                       output t_result r);
        bit               emit;
        logic [GRP_W-1:0] bit_sel;
        emit = 1'b0;
        r    = '0;
        if (last) begin
            r.is_status = 1'b1;
            r.msg_valid = hdr_ok_q && (pos_q >= POS_SAT) && (b == TERMINATOR);
            if (r.msg_valid)
                r.slot_number = {8'd0, slot_lo_q} + {1'b0, slot_hi_q, 7'd0};
            clear_frame();
            return 1'b1;
        end
        if (pos_q < HDR_LEN) begin
            if (b != FRAME_HDR[pos_q*8 +: 8])
                hdr_ok_q = 1'b0;
        end else if (pos_q == POS_SLOT_LO) begin
            slot_lo_q = b;
        end else if (pos_q == POS_SLOT_HI) begin
            slot_hi_q = b;
        end else if (grp_q == '0) begin
            // collector: bit 7 is dropped
            hibits_q = b[6:0];
            grp_q    = 3'd1;
        end else begin
            bit_sel     = grp_q - 3'd1;
            r.out_byte  = {hibits_q[bit_sel], b[6:0]};
            emit        = 1'b1;
            grp_q       = grp_q + 3'd1;
        end
        if (pos_q < POS_SAT)
            pos_q = pos_q + 4'd1;
        return emit;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] seen);
        if (seen !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
            err_cnt++;
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_result want;
        if (!i_rst_n) begin
            clear_frame();
            decoded_q.delete();
        end else begin
            if (i_in_tvalid && i_in_tready) begin
                if (unpack_byte(i_in_tdata, i_in_tlast, want))
                    decoded_q.push_back(want);
            end
            if (i_out_tvalid && i_out_tready) begin
                if (decoded_q.size() == 0) begin
                    $error("unexpected output transfer: tdata 0x%0h tuser %b",
                           i_out_tdata, i_out_tuser);
                    err_cnt++;
                end else begin
                    want = decoded_q.pop_front();
                    check_field("out_byte", 32'(want.out_byte), 32'(i_out_tdata[7:0]));
                    check_field("msg_valid", 32'(want.msg_valid), 32'(i_out_tdata[8]));
                    check_field("slot_number", 32'(want.slot_number),
                                32'(i_out_tdata[24:9]));
                    check_field("tdata pad", 32'd0, 32'(i_out_tdata[31:25]));
                    check_field("is_status", 32'(want.is_status), 32'(i_out_tuser));
                    chk_cnt++;
                end
            end
        end
        o_pending <= decoded_q.size();
    end

endmodule

// ===== dv/tb_sysex_dump_frame_parser_core.sv =====
`timescale 1ns / 1ps

module tb_sysex_dump_frame_parser_core;
    import sdfp_pkg::*;

    localparam int RAND_ITEMS  = 900;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_LIMIT = 100000;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata  = '0;
    logic                   s_axis_tlast  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;

    int chk_pending;
    int chk_errors;
    int chk_checked;

    logic [7:0] frame[$];
    int         n_items     = 0;
    int         n_frames    = 0;
    int         hold_reqs   = 0;
    int         hold_served = 0;
    bit         src_idle_on  = 1'b0;
    bit         sink_idle_on = 1'b0;

    always #2 i_clk = ~i_clk;

    sysex_dump_frame_parser_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    sysex_unpack_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_tvalid  (s_axis_tvalid),
        .i_in_tready  (s_axis_tready),
        .i_in_tdata   (s_axis_tdata),
        .i_in_tlast   (s_axis_tlast),
        .i_out_tvalid (m_axis_tvalid),
        .i_out_tready (m_axis_tready),
        .i_out_tdata  (m_axis_tdata),
        .i_out_tuser  (m_axis_tuser),
        .o_pending    (chk_pending),
        .o_errors     (chk_errors),
        .o_checked    (chk_checked)
    );

    initial begin
        #4_000_000;
        $display("sysex_dump_frame_parser_core: mismatch");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // output side: random stalls, plus one long hold on request
    initial begin : sink
        int stall;
        forever begin
            @(posedge i_clk);
            if (hold_served != hold_reqs) begin
                hold_served = hold_reqs;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (sink_idle_on && $urandom_range(0, 99) < 25) begin
                m_axis_tready <= 1'b0;
                stall = idle_len();
                repeat (stall) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = 0;
        if (src_idle_on && $urandom_range(0, 99) < 30)
            gap = idle_len();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        n_items++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame.size(); i++)
            send_byte(frame[i], i == frame.size() - 1);
        n_frames++;
    endtask

    task automatic push_header();
        for (int i = 0; i < HDR_LEN; i++)
            frame.push_back(hdr_byte(POS_W'(i)));
    endtask

    task automatic build_frame(input int n_payload);
        frame.delete();
        push_header();
        frame.push_back(8'($urandom_range(0, 255)));
        frame.push_back(8'($urandom_range(0, 255)));
        repeat (n_payload) frame.push_back(8'($urandom_range(0, 255)));
        frame.push_back(TERMINATOR);
    endtask

    task automatic wait_drained();
        int waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (chk_pending != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int         kind;
        int         cut;
        logic [7:0] term;
        bit         hold_done;
        bit         paused;
        hold_done = 1'b0;
        paused    = 1'b0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // lone terminator: shortest possible message
        frame.delete();
        frame.push_back(TERMINATOR);
        send_frame();
        // good frame with one data byte, slot and collector at all ones
        frame.delete();
        push_header();
        frame.push_back(8'hff);
        frame.push_back(8'hff);
        frame.push_back(8'hff);
        frame.push_back(8'h00);
        frame.push_back(TERMINATOR);
        send_frame();
        // header miss and wrong terminator; data still streams out
        frame.delete();
        push_header();
        frame[3] = frame[3] ^ 8'h01;
        frame.push_back(8'h00);
        frame.push_back(8'h00);
        frame.push_back(8'h00);
        frame.push_back(8'hff);
        frame.push_back(8'h00);
        send_frame();

        while (n_items < RAND_ITEMS + 29) begin
            src_idle_on  = $urandom_range(0, 3) != 0;
            sink_idle_on = $urandom_range(0, 3) != 0;
            if (!hold_done && n_items >= 300) begin
                // sender keeps going while the output side holds off
                hold_reqs++;
                hold_done = 1'b1;
            end
            if (!paused && n_items >= 600) begin
                wait_drained();
                paused = 1'b1;
            end
            build_frame($urandom_range(0, 99) < 85 ? $urandom_range(1, 20)
                                                   : $urandom_range(21, 60));
            kind = $urandom_range(0, 99);
            if (kind < 65) begin
                // well formed
            end else if (kind < 73) begin
                cut = $urandom_range(0, HDR_LEN - 1);
                frame[cut] = frame[cut] ^ 8'($urandom_range(1, 255));
            end else if (kind < 81) begin
                term = 8'($urandom_range(0, 255));
                if (term == TERMINATOR)
                    term = 8'h00;
                frame[frame.size() - 1] = term;
            end else if (kind < 88) begin
                // too short: ends at or before index 11
                cut = $urandom_range(1, 12);
                while (frame.size() > cut) void'(frame.pop_back());
                if ($urandom_range(0, 1) != 0)
                    frame[frame.size() - 1] = TERMINATOR;
            end else if (kind < 95) begin
                frame.delete();
                repeat ($urandom_range(1, 20)) frame.push_back(8'($urandom_range(0, 255)));
            end else begin
                build_frame(1);
            end
            send_frame();
        end

        wait_drained();
        if (chk_pending != 0)
            $error("%0d expected results never arrived", chk_pending);
        $display("covered %0d frames, %0d bytes in, %0d output items checked,",
                 n_frames, n_items, chk_checked);
        $display("including a long output hold and a pause until fully drained");
        if (chk_errors == 0 && chk_pending == 0)
            $display("sysex_dump_frame_parser_core: match");
        else
            $display("sysex_dump_frame_parser_core: mismatch");
        $finish;
    end

endmodule
